/* sv/assert_macros.svh */
// Assertion macros used by the RTL of the block pool allocator.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (conseq)) else $error(msg);

`endif

/* sv/fbpa_pkg.sv */
// Package of the fixed block pool allocator: sizes, codes and payload types.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package fbpa_pkg;

	localparam int unsigned BLOCK_CAP  = 256;
	localparam int unsigned IDX_W      = $clog2(BLOCK_CAP);
	localparam int unsigned CNT_W      = $clog2(BLOCK_CAP + 1);
	localparam int unsigned BLOCKS_W   = 9;
	localparam int unsigned BYTES_W    = 16;
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned SPAN_W     = CNT_W + BYTES_W;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BASE   = CFG_IDX_W'(2);

	localparam logic [BLOCKS_W-1:0] BLOCKS_RST = BLOCKS_W'(256);
	localparam logic [BYTES_W-1:0]  BYTES_RST  = BYTES_W'(64);
	localparam logic [ADDR_W-1:0]   BASE_RST   = '0;

	typedef enum logic [1:0] {
		ACT_ALLOC    = 2'd0,
		ACT_FREE     = 2'd1,
		ACT_FREE_ALL = 2'd2,
		ACT_CHECK    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	// One free-list link: successor index plus end-of-list mark.
	typedef struct packed {
		logic             last;
		logic [IDX_W-1:0] idx;
	} link_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  granted_index;
		logic [ADDR_W-1:0] granted_address;
		logic              inside_pool;
	} rsp_t;

	// Clamp a configured block count to the built capacity.
	function automatic logic [CNT_W-1:0] clamp_blocks(input logic [BLOCKS_W-1:0] n);
		logic [CNT_W-1:0] r;
		if (n > BLOCKS_W'(BLOCK_CAP))
			r = CNT_W'(BLOCK_CAP);
		else
			r = CNT_W'(n);
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/fbpa_req_if.sv */
// Request channel of the block pool allocator: valid/ready plus one request beat.
// Depends on fbpa_pkg for the action code and widths.
`default_nettype none

interface fbpa_req_if import fbpa_pkg::*;;
	logic              valid;
	logic              ready;
	action_t           action;
	logic [IDX_W-1:0]  block_index;
	logic [ADDR_W-1:0] check_address;

	modport source (output valid, action, block_index, check_address, input ready);
	modport sink (input valid, action, block_index, check_address, output ready);
endinterface

`default_nettype wire

/* sv/fbpa_rsp_if.sv */
// Response channel of the block pool allocator: valid/ready plus one result beat.
// Depends on fbpa_pkg for the status code and widths.
`default_nettype none

interface fbpa_rsp_if import fbpa_pkg::*;;
	logic              valid;
	logic              ready;
	status_t           status;
	logic [IDX_W-1:0]  granted_index;
	logic [ADDR_W-1:0] granted_address;
	logic              inside_pool;

	modport source (output valid, status, granted_index, granted_address, inside_pool,
		input ready);
	modport sink (input valid, status, granted_index, granted_address, inside_pool,
		output ready);
endinterface

`default_nettype wire

/* sv/fixed_block_pool_allocator.sv */
// Fixed-size block pool allocator: LIFO free list in a link memory plus a bump counter.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if and assert_macros.svh.
//
//   channel   dir   handshake          carries
//   req       in    valid/ready        action, block_index, check_address
//   rsp       out   valid/ready        status, granted_index, granted_address, inside_pool
//   cfg       in    cfg_wr_en only     cfg_index, cfg_data
//
// One request beat per cycle while req.ready is high; its response is registered on acceptance.
// Back-to-back pops run at full rate: the head's link is held in a register or arrives
// from the registered read of the link memory issued by the previous pop.
// Reset (arst_n low) empties the list, clears the bump counter and loads register defaults.
// A two-entry output buffer takes one more beat while a response is stalled; req.ready
// drops only when both entries are full.
`default_nettype none

module fixed_block_pool_allocator import fbpa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fbpa_req_if.sink                   req,
	fbpa_rsp_if.source                 rsp,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [BLOCKS_W-1:0] blocks_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [ADDR_W-1:0]   base_q;
	logic [SPAN_W-1:0]   span_q;

	logic [IDX_W-1:0]    head_q;
	logic                empty_q;
	link_t               link_q;
	logic                from_mem_q;
	logic [CNT_W-1:0]    bump_q;

	link_t               link_mem [BLOCK_CAP];
	link_t               rd_q;

	rsp_t                out_q;
	rsp_t                skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;

	logic                accept;
	logic                out_pop;
	logic [CNT_W-1:0]    n_eff;
	link_t               cur_link;
	logic                list_pop;
	logic                bump_take;
	logic                push;
	logic [IDX_W-1:0]    grant_idx;
	logic [IDX_W+BYTES_W-1:0] grant_off;
	logic [ADDR_W-1:0]   check_off;
	rsp_t                new_rsp;

	logic [CNT_W-1:0]    span_n;
	logic [BYTES_W-1:0]  span_bytes;

	assign accept   = req.valid && req.ready;
	assign out_pop  = out_valid_q && rsp.ready;
	assign req.ready = !skid_valid_q;

	assign n_eff    = clamp_blocks(blocks_q);
	assign cur_link = from_mem_q ? rd_q : link_q;

	assign list_pop  = accept && (req.action == ACT_ALLOC) && !empty_q;
	assign bump_take = accept && (req.action == ACT_ALLOC) && empty_q && (bump_q < n_eff);
	assign push      = accept && (req.action == ACT_FREE)
		&& ({1'b0, req.block_index} < n_eff);

	assign grant_idx = empty_q ? bump_q[IDX_W-1:0] : head_q;
	assign grant_off = (IDX_W+BYTES_W)'(grant_idx) * (IDX_W+BYTES_W)'(bytes_q);
	assign check_off = req.check_address - base_q;

	always_comb begin
		new_rsp = '{status: ST_OK, granted_index: '0, granted_address: '0,
			inside_pool: 1'b0};
		unique case (req.action)
			ACT_ALLOC: begin
				if (!empty_q || (bump_q < n_eff)) begin
					new_rsp.granted_index   = grant_idx;
					new_rsp.granted_address = base_q + ADDR_W'(grant_off);
				end else begin
					new_rsp.status = ST_EXHAUSTED;
				end
			end
			ACT_FREE: begin
				if ({1'b0, req.block_index} >= n_eff)
					new_rsp.status = ST_RANGE;
			end
			ACT_FREE_ALL: ;
			ACT_CHECK: begin
				new_rsp.inside_pool = (check_off < ADDR_W'(span_q));
			end
			default: ;
		endcase
	end

	// Pool span follows the register being written so it is ready for the next beat.
	assign span_n     = (cfg_index == CFG_BLOCKS) ? clamp_blocks(cfg_data[BLOCKS_W-1:0])
		: n_eff;
	assign span_bytes = (cfg_index == CFG_BYTES) ? cfg_data[BYTES_W-1:0] : bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q <= BLOCKS_RST;
			bytes_q  <= BYTES_RST;
			base_q   <= BASE_RST;
			span_q   <= SPAN_W'(BLOCK_CAP) * SPAN_W'(BYTES_RST);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_BLOCKS: blocks_q <= cfg_data[BLOCKS_W-1:0];
				CFG_BYTES:  bytes_q  <= cfg_data[BYTES_W-1:0];
				CFG_BASE:   base_q   <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
			span_q <= SPAN_W'(span_n) * SPAN_W'(span_bytes);
		end
	end

	// Free-list head, cached link of the head and bump counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			empty_q    <= 1'b1;
			link_q     <= '0;
			from_mem_q <= 1'b0;
			bump_q     <= '0;
		end else if (accept) begin
			if (list_pop) begin
				head_q     <= cur_link.idx;
				empty_q    <= cur_link.last;
				from_mem_q <= 1'b1;
			end
			if (bump_take)
				bump_q <= bump_q + CNT_W'(1);
			if (push) begin
				head_q     <= req.block_index;
				empty_q    <= 1'b0;
				link_q     <= '{last: empty_q, idx: head_q};
				from_mem_q <= 1'b0;
			end
			if (req.action == ACT_FREE_ALL) begin
				head_q  <= '0;
				empty_q <= 1'b1;
				bump_q  <= '0;
			end
		end
	end

	// Link memory: write on push, fetch the successor of the new head on pop.
	always_ff @(posedge clk) begin
		if (push)
			link_mem[req.block_index] <= '{last: empty_q, idx: head_q};
	end

	always_ff @(posedge clk) begin
		if (list_pop)
			rd_q <= link_mem[cur_link.idx];
	end

	// Output register with one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_pop)
					skid_valid_q <= 1'b0;
			end else if (accept) begin
				if (out_valid_q && !out_pop)
					skid_valid_q <= 1'b1;
				else
					out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop)
				out_q <= skid_q;
		end else if (accept) begin
			if (out_valid_q && !out_pop)
				skid_q <= new_rsp;
			else
				out_q <= new_rsp;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_q.status;
	assign rsp.granted_index   = out_q.granted_index;
	assign rsp.granted_address = out_q.granted_address;
	assign rsp.inside_pool     = out_q.inside_pool;

`include "assert_macros.svh"

	`ASSERT_CLK(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid entry without output beat")
	`ASSERT_CLK(a_bump_bounded, bump_q <= CNT_W'(BLOCK_CAP), "bump counter beyond capacity")
	`ASSERT_NEXT(a_bump_advance, bump_take && !list_pop, bump_q == $past(bump_q) + CNT_W'(1), "bump counter did not advance on grant")
	`ASSERT_NEXT(a_push_fills_list, push, !empty_q && head_q == $past(req.block_index), "free did not become list head")

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for the fixed block pool allocator: drives the request and register ports,
// predicts every response and checks it. Depends on fbpa_pkg, fbpa_req_if and fbpa_rsp_if.
`timescale 1ns / 1ps

module tb import fbpa_pkg::*;;

	localparam int unsigned STALL_LIMIT = 2000;

	// Tracks free list, bump counter and registers; holds the responses still owed.
	class pool_scoreboard;
		int unsigned         failures;
		rsp_t                owed_responses[$];
		logic [BLOCKS_W-1:0] reg_blocks;
		logic [BYTES_W-1:0]  reg_bytes;
		logic [ADDR_W-1:0]   reg_base;
		link_t               links[BLOCK_CAP];
		logic [IDX_W-1:0]    head;
		logic                list_empty;
		logic [CNT_W-1:0]    bump;

		function new();
			failures = 0;
			reg_blocks = BLOCKS_RST;
			reg_bytes = BYTES_RST;
			reg_base = BASE_RST;
			foreach (links[i])
				links[i] = '0;
			head = '0;
			list_empty = 1'b1;
			bump = '0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BLOCKS: reg_blocks = data[BLOCKS_W-1:0];
				CFG_BYTES:  reg_bytes = data[BYTES_W-1:0];
				CFG_BASE:   reg_base = data[ADDR_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CNT_W-1:0] usable_blocks();
			return (reg_blocks > BLOCKS_W'(BLOCK_CAP)) ? CNT_W'(BLOCK_CAP) : CNT_W'(reg_blocks);
		endfunction

		function longint unsigned pool_span();
			return longint'(usable_blocks()) * longint'(reg_bytes);
		endfunction

		// Advance the pool state by one request and queue the response it owes.
		function rsp_t apply_request(action_t act, logic [IDX_W-1:0] idx,
				logic [ADDR_W-1:0] addr);
			rsp_t              r;
			logic [IDX_W-1:0]  blk;
			logic [ADDR_W-1:0] off;
			r = '0;
			r.status = ST_OK;
			case (act)
				ACT_ALLOC: begin
					if (!list_empty) begin
						blk = head;
						head = links[blk].idx;
						list_empty = links[blk].last;
					end else if (bump < usable_blocks()) begin
						blk = bump[IDX_W-1:0];
						bump = bump + CNT_W'(1);
					end else begin
						r.status = ST_EXHAUSTED;
					end
					if (r.status == ST_OK) begin
						r.granted_index = blk;
						r.granted_address = reg_base + ADDR_W'(blk) * ADDR_W'(reg_bytes);
					end
				end
				ACT_FREE: begin
					if (CNT_W'(idx) >= usable_blocks()) begin
						r.status = ST_RANGE;
					end else begin
						links[idx].idx = head;
						links[idx].last = list_empty;
						head = idx;
						list_empty = 1'b0;
					end
				end
				ACT_FREE_ALL: begin
					list_empty = 1'b1;
					head = '0;
					bump = '0;
				end
				default: begin
					off = addr - reg_base;
					r.inside_pool = longint'(off) < pool_span();
				end
			endcase
			owed_responses.push_back(r);
			return r;
		endfunction

		task report(string msg);
			$display("[%0t] response mismatch: %s", $realtime, msg);
			failures++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (owed_responses.size() == 0) begin
				report("response beat with nothing owed");
			end else begin
				want = owed_responses.pop_front();
				if (got.status != want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.granted_index != want.granted_index)
					report($sformatf("index %0d, want %0d", got.granted_index,
						want.granted_index));
				if (got.granted_address != want.granted_address)
					report($sformatf("address %h, want %h", got.granted_address,
						want.granted_address));
				if (got.inside_pool != want.inside_pool)
					report($sformatf("inside %0b, want %0b", got.inside_pool,
						want.inside_pool));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit gaps_on;

	pool_scoreboard sb = new();
	logic [IDX_W-1:0] granted_blocks[$];

	fbpa_req_if req_ch();
	fbpa_rsp_if rsp_ch();

	fixed_block_pool_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_item(input action_t act, input logic [IDX_W-1:0] idx,
			input logic [ADDR_W-1:0] addr);
		rsp_t exp;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.action = act;
		req_ch.block_index = idx;
		req_ch.check_address = addr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		exp = sb.apply_request(act, idx, addr);
		if (act == ACT_ALLOC && exp.status == ST_OK)
			granted_blocks.push_back(exp.granted_index);
		if (act == ACT_FREE_ALL)
			granted_blocks.delete();
	endtask

	// Drop valid and hold until every owed response has come back.
	task automatic settle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.owed_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		sb.set_register(idx, data);
	endtask

	task automatic configure(input logic [BLOCKS_W-1:0] blocks,
			input logic [BYTES_W-1:0] bytes, input logic [ADDR_W-1:0] base);
		write_register(CFG_BLOCKS, CFG_DATA_W'(blocks));
		write_register(CFG_BYTES, CFG_DATA_W'(bytes));
		write_register(CFG_BASE, CFG_DATA_W'(base));
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic random_item(input int unsigned alloc_pct);
		int unsigned       r;
		int unsigned       pos;
		longint unsigned   span;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] addr;
		idx = IDX_W'($urandom);
		addr = $urandom;
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			send_item(ACT_ALLOC, idx, addr);
		end else if ($urandom_range(0, 99) < 3) begin
			send_item(ACT_FREE_ALL, idx, addr);
		end else if ($urandom_range(0, 99) < 58) begin
			// mostly give back a block that is out; now and then free it twice
			if (granted_blocks.size() != 0 && $urandom_range(0, 9) < 8) begin
				pos = $urandom_range(0, granted_blocks.size() - 1);
				idx = granted_blocks[pos];
				if ($urandom_range(0, 19) != 0)
					granted_blocks.delete(pos);
			end else if ($urandom_range(0, 1) == 0) begin
				idx = IDX_W'($urandom_range(0, 63));
			end
			send_item(ACT_FREE, idx, addr);
		end else begin
			span = sb.pool_span();
			case ($urandom_range(0, 3))
				0: ;
				1: addr = sb.reg_base + ADDR_W'($urandom_range(0, 32'(span) + 16));
				2: addr = sb.reg_base + ADDR_W'(span) - ADDR_W'($urandom_range(0, 1));
				default: addr = sb.reg_base - ADDR_W'($urandom_range(1, 4));
			endcase
			send_item(ACT_CHECK, idx, addr);
		end
	endtask

	// Response side: stall in bursts, check every accepted beat.
	initial begin : rsp_side
		int unsigned hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				rsp_ch.ready = 1'b0;
				hold--;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready = 1'b0;
				hold = $urandom_range(1, 17) - 1;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status = rsp_ch.status;
			got.granted_index = rsp_ch.granted_index;
			got.granted_address = rsp_ch.granted_address;
			got.inside_pool = rsp_ch.inside_pool;
			sb.check_response(got);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned         count;
		int unsigned         alloc_pct;
		logic [BLOCKS_W-1:0] blk;
		logic [BYTES_W-1:0]  byt;
		logic [ADDR_W-1:0]   bas;
		arst_n = 1'b0;
		gaps_on = 1'b1;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_BLOCKS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_ALLOC;
		req_ch.block_index = '0;
		req_ch.check_address = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: 256 blocks of 64 bytes at address zero
		send_item(ACT_CHECK, '0, 32'h0000_0000);
		send_item(ACT_CHECK, '0, 32'h0000_3FFF);
		send_item(ACT_CHECK, '0, 32'h0000_4000);
		send_item(ACT_CHECK, '1, 32'hFFFF_FFFF);
		repeat (3) send_item(ACT_ALLOC, '0, '0);
		send_item(ACT_FREE, 8'd1, '0);
		send_item(ACT_FREE, 8'd2, '0);
		send_item(ACT_FREE, 8'd255, '0);
		repeat (4) send_item(ACT_ALLOC, '0, '0);
		send_item(ACT_FREE_ALL, '0, '0);
		send_item(ACT_ALLOC, '1, '1);
		settle();

		// two widest blocks in a pool that wraps past the top of the address space
		configure(9'd2, 16'hFFFF, 32'hFFFF_0000);
		repeat (3) send_item(ACT_ALLOC, '0, '0);
		send_item(ACT_FREE, 8'd2, '0);
		send_item(ACT_FREE, 8'd1, '0);
		send_item(ACT_FREE, 8'd1, '0);
		repeat (3) send_item(ACT_ALLOC, '0, '0);
		send_item(ACT_CHECK, '0, 32'h0001_FFFD);
		send_item(ACT_CHECK, '0, 32'h0001_FFFE);
		settle();

		configure(9'd0, 16'd8, 32'h0000_0000);
		send_item(ACT_ALLOC, '0, '0);
		send_item(ACT_FREE, 8'd0, '0);
		send_item(ACT_CHECK, '0, 32'h0000_0000);
		settle();

		for (int p = 0; p < 8; p++) begin
			byt = ($urandom_range(0, 3) == 0) ? BYTES_W'($urandom_range(0, 7)) :
				BYTES_W'($urandom_range(8, 65535));
			bas = $urandom;
			alloc_pct = 45;
			count = 130;
			blk = BLOCKS_W'($urandom_range(1, 48));
			case (p)
				0: begin
					// oversized count clamps to capacity; run the pool dry
					blk = 9'd511;
					byt = 16'hFFFF;
					bas = 32'hFFFF_FFFF;
					alloc_pct = 92;
					count = 320;
				end
				1: begin
					blk = 9'd1;
					byt = 16'd8;
					bas = 32'h0000_0000;
					alloc_pct = 50;
					count = 60;
				end
				2: begin
					blk = 9'd0;
					count = 30;
				end
				7: count = 150;
				default: ;
			endcase
			gaps_on = (p != 4 && p != 7);
			configure(blk, byt, bas);
			repeat (count) random_item(alloc_pct);
			settle();
		end

		if (sb.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
